### design/elog_pkg.sv
package elog_pkg;

  // Sizing of the storage.
  localparam int LOG_DEPTH    = 256;
  localparam int QUEUE_DEPTH  = 16;
  localparam int RECORD_WORDS = 4;

  localparam int LOG_AW   = $clog2(LOG_DEPTH);
  localparam int LOG_LW   = $clog2(LOG_DEPTH + 1);
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  // Field widths.
  localparam int ADDR_W      = 16;
  localparam int CODE_W      = 16;
  localparam int SEQ_W       = 16;
  localparam int STAMP_W     = 32;
  localparam int OFFSET_W    = 8;
  localparam int CFG_LOG_W   = 9;
  localparam int CFG_QUEUE_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Request modes.
  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_DRAIN  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_EMPTY      = 2'd2;
  localparam logic [1:0] STAT_BAD_OFFSET = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_ENTRIES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENTRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_BASE      = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] stamp;
    logic [CODE_W-1:0]  code;
  } evt_t;

  localparam int EVT_W = $bits(evt_t);

  typedef struct packed {
    logic [1:0]          mode;
    logic [CODE_W-1:0]   fault_code;
    logic [STAMP_W-1:0]  timestamp;
    logic [OFFSET_W-1:0] back_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SEQ_W-1:0]   seq_number;
    logic [STAMP_W-1:0] event_time;
    logic [CODE_W-1:0]  event_code_out;
    logic [ADDR_W-1:0]  record_address;
    logic [CODE_W-1:0]  latest_code;
  } rsp_t;

  // Control from the sequencer to the staging queue.
  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
    evt_t wdata;
  } queue_ctl_t;

  // Control from the sequencer to the ring log.
  typedef struct packed {
    logic              rd;
    logic [LOG_AW-1:0] rd_idx;
    logic              wr;
    logic              clr;
    evt_t              wdata;
  } ring_ctl_t;

  // Effective ring size, clamped to the legal range.
  function automatic logic [LOG_LW-1:0] log_size(input logic [CFG_LOG_W-1:0] cfg);
    logic [LOG_LW-1:0] res;
    if (cfg == '0) begin
      res = LOG_LW'(1);
    end else if (int'(cfg) > LOG_DEPTH) begin
      res = LOG_LW'(LOG_DEPTH);
    end else begin
      res = LOG_LW'(cfg);
    end
    return res;
  endfunction

  // Effective queue size, clamped to the legal range.
  function automatic logic [QUEUE_CW-1:0] queue_size(input logic [CFG_QUEUE_W-1:0] cfg);
    logic [QUEUE_CW-1:0] res;
    if (cfg == '0) begin
      res = QUEUE_CW'(1);
    end else if (int'(cfg) > QUEUE_DEPTH) begin
      res = QUEUE_CW'(QUEUE_DEPTH);
    end else begin
      res = QUEUE_CW'(cfg);
    end
    return res;
  endfunction

  // Word address of a ring record, wrapping at the address width.
  function automatic logic [ADDR_W-1:0] rec_addr(input logic [ADDR_W-1:0] base,
                                                 input logic [LOG_AW-1:0] idx);
    return base + ADDR_W'(int'(idx) * RECORD_WORDS);
  endfunction

endpackage

### design/elog_req_if.sv
interface elog_req_if;
  import elog_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/elog_rsp_if.sv
interface elog_rsp_if;
  import elog_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/elog_ram.sv
module elog_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/elog_queue.sv
module elog_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [elog_pkg::QUEUE_CW-1:0]  queue_size_i,
  input  elog_pkg::queue_ctl_t           ctl_i,
  output logic [elog_pkg::QUEUE_CW-1:0]  count_o,
  output elog_pkg::evt_t                 head_data_o
);
  import elog_pkg::*;

  logic [QUEUE_AW-1:0] head_q, head_d;
  logic [QUEUE_AW-1:0] tail_q, tail_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic [EVT_W-1:0]    rdata;

  // Pointers advance and wrap at the configured size.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.push) begin
      if (QUEUE_CW'(tail_q) + QUEUE_CW'(1) >= queue_size_i) begin
        tail_d = '0;
      end else begin
        tail_d = tail_q + QUEUE_AW'(1);
      end
      count_d = count_q + QUEUE_CW'(1);
    end
    if (ctl_i.pop) begin
      if (QUEUE_CW'(head_q) + QUEUE_CW'(1) >= queue_size_i) begin
        head_d = '0;
      end else begin
        head_d = head_q + QUEUE_AW'(1);
      end
      count_d = count_q - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Event storage: written at the tail, read at the head.
  elog_ram #(
    .WIDTH (EVT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .waddr_i (tail_q),
    .wdata_i (ctl_i.wdata),
    .re_i    (ctl_i.rd),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign count_o     = count_q;
  assign head_data_o = evt_t'(rdata);

endmodule

### design/elog_ring.sv
module elog_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [elog_pkg::LOG_LW-1:0]  log_size_i,
  input  elog_pkg::ring_ctl_t          ctl_i,
  output logic [elog_pkg::LOG_AW-1:0]  newest_o,
  output logic [elog_pkg::LOG_AW-1:0]  next_idx_o,
  output elog_pkg::evt_t               rdata_o
);
  import elog_pkg::*;

  logic [LOG_AW-1:0]    newest_q, newest_d;
  logic [LOG_AW-1:0]    next_idx;
  logic [LOG_DEPTH-1:0] valid_q, valid_d;
  logic                 rvalid_q;
  logic [EVT_W-1:0]     ram_rdata;

  // The next ring slot wraps at the configured size.
  always_comb begin
    if (LOG_LW'(newest_q) >= log_size_i - LOG_LW'(1)) begin
      next_idx = '0;
    end else begin
      next_idx = newest_q + LOG_AW'(1);
    end
  end

  // Entry valid bits stand for the zeroed store; clear drops those in use.
  always_comb begin
    valid_d  = valid_q;
    newest_d = newest_q;
    if (ctl_i.clr) begin
      for (int i = 0; i < LOG_DEPTH; i++) begin
        if (LOG_LW'(i) < log_size_i) begin
          valid_d[i] = 1'b0;
        end
      end
      newest_d = '0;
    end
    if (ctl_i.wr) begin
      valid_d[next_idx] = 1'b1;
      newest_d          = next_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      newest_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      newest_q <= newest_d;
      if (ctl_i.rd) begin
        rvalid_q <= valid_q[ctl_i.rd_idx];
      end
    end
  end

  elog_ram #(
    .WIDTH (EVT_W),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr),
    .waddr_i (next_idx),
    .wdata_i (ctl_i.wdata),
    .re_i    (ctl_i.rd),
    .raddr_i (ctl_i.rd_idx),
    .rdata_o (ram_rdata)
  );

  assign newest_o   = newest_q;
  assign next_idx_o = next_idx;
  assign rdata_o    = rvalid_q ? evt_t'(ram_rdata) : '0;

endmodule

### design/event_logger_fifo_ring_unit.sv
// Fault event logger with a staging queue and a ring log.
//
// Requests arrive on req_i (valid/ready) and carry a mode: record an event,
// drain one queued event into the ring log, read back an entry some places
// before the newest one, or clear the log. Each request gives exactly one
// result on rsp_o (valid/ready). Registers are written through the cfg_*
// port, which is always ready; write them only while the block is idle.
//
// Each request runs as an accept step and an execute step: the accept cycle
// issues the read of the queue or log memory, and the execute step uses the
// registered read data, writes back and loads the result register. A new
// request is taken only once the previous one has left its execute step.
// The result becomes valid at the edge that ends the execute step.
//
// When the receiver stalls, the result register holds; a second request can
// be accepted meanwhile, and it then waits in its execute cycle until the
// result register is free. Reset empties the queue, zeroes the log through
// its entry valid bits at once and restores the register defaults; no
// clearing pass is needed.
module event_logger_fifo_ring_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  elog_req_if.sink                          req_i,
  elog_rsp_if.source                        rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [elog_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [elog_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import elog_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;
  localparam int   IW     = LOG_LW + 1;

  logic                   state_q, state_d;
  req_t                   req_q;
  logic                   bad_q;
  logic [LOG_AW-1:0]      rd_idx_q;
  rsp_t                   rsp_q, rsp_d;
  logic                   out_valid_q;
  logic [SEQ_W-1:0]       last_seq_q, last_seq_d;
  logic [CODE_W-1:0]      last_code_q, last_code_d;
  logic [CFG_LOG_W-1:0]   cfg_log_q;
  logic [CFG_QUEUE_W-1:0] cfg_queue_q;
  logic [ADDR_W-1:0]      cfg_base_q;

  logic                   accept;
  logic                   fire;
  logic [LOG_LW-1:0]      l_size;
  logic [QUEUE_CW-1:0]    q_size;
  logic [QUEUE_CW-1:0]    q_count;
  evt_t                   q_head;
  logic [LOG_AW-1:0]      newest;
  logic [LOG_AW-1:0]      next_idx;
  evt_t                   ring_rdata;
  queue_ctl_t             q_ctl;
  ring_ctl_t              r_ctl;
  logic                   bad_d;
  logic [IW-1:0]          back_sum;
  logic [LOG_AW-1:0]      rd_idx_d;
  logic [SEQ_W-1:0]       new_seq;

  assign l_size = log_size(cfg_log_q);
  assign q_size = queue_size(cfg_queue_q);

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_log_q   <= CFG_LOG_W'(256);
      cfg_queue_q <= CFG_QUEUE_W'(16);
      cfg_base_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LOG_ENTRIES:   cfg_log_q   <= cfg_data_i[CFG_LOG_W-1:0];
        CFG_QUEUE_ENTRIES: cfg_queue_q <= cfg_data_i[CFG_QUEUE_W-1:0];
        CFG_LOG_BASE:      cfg_base_q  <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes.
  assign req_i.ready   = (state_q == S_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign fire          = (state_q == S_EXEC) && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

  // Read-back index: offset places before the newest entry, around the ring.
  always_comb begin
    bad_d = IW'(req_i.payload.back_offset) >= IW'(l_size);
    if (IW'(newest) >= IW'(req_i.payload.back_offset)) begin
      back_sum = IW'(newest) - IW'(req_i.payload.back_offset);
    end else begin
      back_sum = IW'(newest) + IW'(l_size) - IW'(req_i.payload.back_offset);
    end
    if (back_sum >= IW'(LOG_DEPTH)) begin
      back_sum = back_sum - IW'(LOG_DEPTH);
    end
    rd_idx_d = back_sum[LOG_AW-1:0];
  end

  // Execute step: build the result and the write-back for the held request.
  always_comb begin
    rsp_d       = '0;
    last_seq_d  = last_seq_q;
    last_code_d = last_code_q;
    new_seq     = last_seq_q + SEQ_W'(1);
    state_d     = state_q;

    q_ctl       = '0;
    q_ctl.rd    = accept && (req_i.payload.mode == MODE_DRAIN);
    q_ctl.wdata = '{seq: new_seq, stamp: req_q.timestamp, code: req_q.fault_code};

    r_ctl        = '0;
    r_ctl.rd     = accept && (req_i.payload.mode == MODE_READ);
    r_ctl.rd_idx = rd_idx_d;
    r_ctl.wdata  = q_head;

    if (accept) begin
      state_d = S_EXEC;
    end

    if (fire) begin
      state_d = S_IDLE;
      case (req_q.mode)
        MODE_RECORD: begin
          last_seq_d       = new_seq;
          last_code_d      = req_q.fault_code;
          rsp_d.seq_number = new_seq;
          if (q_count >= q_size) begin
            rsp_d.status = STAT_FULL;
          end else begin
            q_ctl.push           = 1'b1;
            rsp_d.event_time     = req_q.timestamp;
            rsp_d.event_code_out = req_q.fault_code;
          end
        end
        MODE_DRAIN: begin
          if (q_count == '0) begin
            rsp_d.status = STAT_EMPTY;
          end else begin
            q_ctl.pop            = 1'b1;
            r_ctl.wr             = 1'b1;
            rsp_d.seq_number     = q_head.seq;
            rsp_d.event_time     = q_head.stamp;
            rsp_d.event_code_out = q_head.code;
            rsp_d.record_address = rec_addr(cfg_base_q, next_idx);
          end
        end
        MODE_READ: begin
          if (bad_q) begin
            rsp_d.status = STAT_BAD_OFFSET;
          end else begin
            rsp_d.seq_number     = ring_rdata.seq;
            rsp_d.event_time     = ring_rdata.stamp;
            rsp_d.event_code_out = ring_rdata.code;
            rsp_d.record_address = rec_addr(cfg_base_q, rd_idx_q);
          end
        end
        default: begin
          r_ctl.clr  = 1'b1;
          last_seq_d = '0;
        end
      endcase
      rsp_d.latest_code = last_code_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      last_seq_q  <= '0;
      last_code_q <= '0;
    end else begin
      state_q     <= state_d;
      last_seq_q  <= last_seq_d;
      last_code_q <= last_code_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_i.payload;
      bad_q    <= bad_d;
      rd_idx_q <= rd_idx_d;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  elog_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_size_i (q_size),
    .ctl_i        (q_ctl),
    .count_o      (q_count),
    .head_data_o  (q_head)
  );

  elog_ring u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .log_size_i (l_size),
    .ctl_i      (r_ctl),
    .newest_o   (newest),
    .next_idx_o (next_idx),
    .rdata_o    (ring_rdata)
  );

  // The queue never holds more events than it has slots.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A request is followed by its execute cycle before the next one is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request accepted during execute");

  // A loaded result reports the latest code that the step left behind.
  a_latest_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> rsp_o.valid && (rsp_o.payload.latest_code == last_code_q))
    else $error("latest code out of step with state");

endmodule
